// File: hdl/bpir_pkg.sv
// ----------------------------------------------------------------------------
// bpir_pkg
// Shared types and constants for the boost pump interval regulator.
// ----------------------------------------------------------------------------
package bpir_pkg;

  localparam int unsigned IntervalW = 16;
  localparam int unsigned PulsesW   = 16;
  localparam int unsigned DetW      = 4;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;

  // interval rescale thresholds
  localparam logic [IntervalW-1:0] HEAVY_CUT_LIMIT = 16'h0080;
  localparam logic [IntervalW-1:0] MIN_INTERVAL    = 16'h0008;
  localparam logic [IntervalW-1:0] HALVE_LIMIT     = 16'h0010;
  localparam logic [IntervalW-1:0] DOUBLE_LIMIT    = 16'h7FFF;
  localparam logic [IntervalW-1:0] STEP_ADD        = 16'h2000;
  localparam logic [IntervalW-1:0] MAX_INTERVAL    = 16'hFFFF;
  localparam logic [PulsesW-1:0]   MAX_PULSES      = 16'hFFFF;

  // register reset values
  localparam logic [PulsesW-1:0]   HEAVY_LOAD_RST  = 16'd20;
  localparam logic [PulsesW-1:0]   WEAK_RST        = 16'd2;
  localparam logic [DetW-1:0]      DET_GAP_RST     = 4'd5;
  localparam logic [IntervalW-1:0] START_RST       = 16'd4096;

  // event codes
  typedef enum logic [1:0] {
    REQ_PULSE_END = 2'd0,
    REQ_TRIP      = 2'd1,
    REQ_DETECT    = 2'd2,
    REQ_WAKE      = 2'd3
  } req_type_t;

  // register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_HEAVY_LOAD  = 2'd0,
    REG_WEAK        = 2'd1,
    REG_DET_GAP     = 2'd2,
    REG_START_INTVL = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [PulsesW-1:0]   heavy_load_pulses;
    logic [PulsesW-1:0]   weak_pulses;
    logic [DetW-1:0]      detector_gap;
    logic [IntervalW-1:0] start_interval;
  } cfg_t;

  // immediate interval load on a start_interval write
  typedef struct packed {
    logic                 load;
    logic [IntervalW-1:0] value;
  } intvl_load_t;

  typedef struct packed {
    logic                 pump_on;
    logic [PulsesW-1:0]   pump_pulses;
    logic                 skip_next_trip;
    logic [DetW-1:0]      detector_count;
    logic [IntervalW-1:0] wake_interval;
  } state_t;

  typedef struct packed {
    logic                 pump_enable;
    logic [IntervalW-1:0] wake_interval_out;
    logic                 interval_changed;
  } result_t;

endpackage

// File: hdl/bpir_if.sv
// ----------------------------------------------------------------------------
// bpir interfaces
// Event, result and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bpir_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic       power_off;

  modport source (output valid, req_type, power_off, input ready);
  modport sink   (input valid, req_type, power_off, output ready);
endinterface

interface bpir_rsp_if;
  logic        valid;
  logic        ready;
  logic        pump_enable;
  logic [15:0] wake_interval_out;
  logic        interval_changed;

  modport source (output valid, pump_enable, wake_interval_out, interval_changed,
                  input ready);
  modport sink   (input valid, pump_enable, wake_interval_out, interval_changed,
                  output ready);
endinterface

interface bpir_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/boost_pump_interval_regulator_core.sv
// ----------------------------------------------------------------------------
// boost_pump_interval_regulator_core
// Adaptive wakeup interval regulator for a high-voltage boost pump.
// ----------------------------------------------------------------------------
// Each accepted event beat yields exactly one result beat from a registered
// buffer. The state update is combinational compare/shift logic, so
// an event can be accepted on every clock; a two-entry result buffer (output
// register plus skid register) keeps the event side moving while a result
// waits, and ready drops only when both entries are full. Register writes are
// always ready and take effect on the next clock; a start_interval write also
// reloads the live wakeup interval.
module boost_pump_interval_regulator_core (
  input  logic       clk,
  input  logic       rst,
  bpir_req_if.sink   req,
  bpir_rsp_if.source rsp,
  bpir_cfg_if.sink   cfg
);
  import bpir_pkg::*;

  cfg_t        cfg_q;
  intvl_load_t intvl_load;
  state_t      st;
  state_t      st_next;
  logic        changed;
  result_t     res_next;
  result_t     out_res;
  result_t     skid_res;
  logic        out_valid;
  logic        skid_valid;
  logic        accept;
  logic        pop;

  bpir_cfg_regs u_cfg (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cfg_q      (cfg_q),
    .intvl_load (intvl_load)
  );

  bpir_update u_update (
    .st        (st),
    .cfg_q     (cfg_q),
    .req_type  (req.req_type),
    .power_off (req.power_off),
    .st_next   (st_next),
    .changed   (changed)
  );

  assign req.ready = !skid_valid;
  assign accept    = req.valid && req.ready;
  assign pop       = out_valid && rsp.ready;

  // regulator state
  always_ff @(posedge clk) begin
    if (rst) begin
      st.pump_on        <= 1'b0;
      st.pump_pulses    <= '0;
      st.skip_next_trip <= 1'b0;
      st.detector_count <= '0;
      st.wake_interval  <= START_RST;
    end else if (intvl_load.load) begin
      st.wake_interval  <= intvl_load.value;
    end else if (accept) begin
      st <= st_next;
    end
  end

  assign res_next.pump_enable       = st_next.pump_on;
  assign res_next.wake_interval_out = st_next.wake_interval;
  assign res_next.interval_changed  = changed;

  // result buffer control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) skid_valid <= 1'b0;
    end else if (accept) begin
      if (out_valid && !pop) skid_valid <= 1'b1;
      else                   out_valid  <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  // result buffer payload
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) out_res <= skid_res;
    end else if (accept) begin
      if (out_valid && !pop) skid_res <= res_next;
      else                   out_res  <= res_next;
    end
  end

  assign rsp.valid             = out_valid;
  assign rsp.pump_enable       = out_res.pump_enable;
  assign rsp.wake_interval_out = out_res.wake_interval_out;
  assign rsp.interval_changed  = out_res.interval_changed;

`ifndef SYNTHESIS
  // skid entry is only ever filled behind a held output entry
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry valid without output entry");

  // ignored event leaves the regulator state untouched
  a_power_off_hold: assert property (@(posedge clk) disable iff (rst)
    (accept && req.power_off && !cfg.valid) |=> $stable(st))
    else $error("state changed on power-off event");

  // a stalled full buffer keeps the output entry
  a_full_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !rsp.ready) |=> (out_valid && skid_valid && $stable(out_res)))
    else $error("result lost under stall");
`endif

endmodule

// File: hdl/bpir_cfg_regs.sv
// ----------------------------------------------------------------------------
// bpir_cfg_regs
// Register file for thresholds and the start interval.
// ----------------------------------------------------------------------------
module bpir_cfg_regs (
  input  logic                 clk,
  input  logic                 rst,
  bpir_cfg_if.sink             cfg,
  output bpir_pkg::cfg_t       cfg_q,
  output bpir_pkg::intvl_load_t intvl_load
);
  import bpir_pkg::*;

  logic     wr;
  reg_idx_t idx;

  assign cfg.ready = 1'b1;
  assign wr        = cfg.valid;
  assign idx       = reg_idx_t'(cfg.index);

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.heavy_load_pulses <= HEAVY_LOAD_RST;
      cfg_q.weak_pulses       <= WEAK_RST;
      cfg_q.detector_gap      <= DET_GAP_RST;
      cfg_q.start_interval    <= START_RST;
    end else if (wr) begin
      case (idx)
        REG_HEAVY_LOAD:  cfg_q.heavy_load_pulses <= cfg.data[PulsesW-1:0];
        REG_WEAK:        cfg_q.weak_pulses       <= cfg.data[PulsesW-1:0];
        REG_DET_GAP:     cfg_q.detector_gap      <= cfg.data[DetW-1:0];
        REG_START_INTVL: cfg_q.start_interval    <= cfg.data[IntervalW-1:0];
        default: ;
      endcase
    end
  end

  // a start interval write also reloads the live interval
  assign intvl_load.load  = wr && (idx == REG_START_INTVL);
  assign intvl_load.value = cfg.data[IntervalW-1:0];

endmodule

// File: hdl/bpir_update.sv
// ----------------------------------------------------------------------------
// bpir_update
// Next-state logic for one event, including the interval rescale.
// ----------------------------------------------------------------------------
module bpir_update (
  input  bpir_pkg::state_t st,
  input  bpir_pkg::cfg_t   cfg_q,
  input  logic [1:0]       req_type,
  input  logic             power_off,
  output bpir_pkg::state_t st_next,
  output logic             changed
);
  import bpir_pkg::*;

  req_type_t            req;
  logic                 heavy;
  logic                 mid_load;
  logic [IntervalW-1:0] iv_floor;
  logic [IntervalW:0]   iv_sum;
  logic [IntervalW-1:0] iv_new;

  assign req = req_type_t'(req_type);

  // rescale from pulse count
  always_comb begin
    heavy    = st.pump_pulses > cfg_q.heavy_load_pulses;
    mid_load = st.pump_pulses > cfg_q.weak_pulses;
    iv_floor = (st.wake_interval < MIN_INTERVAL) ? MIN_INTERVAL : st.wake_interval;
    iv_sum   = {1'b0, iv_floor} + {1'b0, STEP_ADD};
    if (heavy) begin
      iv_new = (st.wake_interval > HEAVY_CUT_LIMIT) ? (st.wake_interval >> 4)
                                                    : MIN_INTERVAL;
    end else if (mid_load) begin
      iv_new = (iv_floor > HALVE_LIMIT) ? (iv_floor >> 1) : iv_floor;
    end else if (iv_floor < DOUBLE_LIMIT) begin
      iv_new = iv_floor << 1;
    end else begin
      iv_new = iv_sum[IntervalW] ? MAX_INTERVAL : iv_sum[IntervalW-1:0];
    end
  end

  // event dispatch
  always_comb begin
    st_next = st;
    changed = 1'b0;
    if (!power_off) begin
      case (req)
        REQ_PULSE_END: begin
          if (st.pump_on && st.pump_pulses != MAX_PULSES)
            st_next.pump_pulses = st.pump_pulses + 1'b1;
        end
        REQ_TRIP: begin
          st_next.pump_on = 1'b0;
          if (st.skip_next_trip) begin
            st_next.skip_next_trip = 1'b0;
          end else begin
            st_next.wake_interval = iv_new;
            st_next.pump_pulses   = '0;
            changed               = iv_new != st.wake_interval;
          end
        end
        REQ_DETECT: begin
          if (!st.pump_on) begin
            if (st.detector_count > cfg_q.detector_gap) begin
              st_next.skip_next_trip = 1'b1;
              st_next.pump_on        = 1'b1;
              st_next.detector_count = '0;
            end else begin
              st_next.detector_count = st.detector_count + 1'b1;
            end
          end
        end
        REQ_WAKE: st_next.pump_on = 1'b1;
        default: ;
      endcase
    end
  end

endmodule
